// File: rtl/u8sv_pkg.sv
// Shared types, constants and byte classification for the UTF-8 stream validator.
package u8sv_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int OUT_OFF_W   = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] MASK_TOP2  = 8'hc0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] TWO_OVL    = 8'h3e;
  localparam logic [7:0] E0_MASK    = 8'h20;
  localparam logic [7:0] F0_MASK    = 8'h30;
  localparam logic [7:0] F8_MASK    = 8'h38;
  localparam logic [7:0] FC_MASK    = 8'h3c;
  localparam logic [7:0] LEAD_E0    = 8'he0;
  localparam logic [7:0] LEAD_F0    = 8'hf0;
  localparam logic [7:0] LEAD_F8    = 8'hf8;
  localparam logic [7:0] LEAD_FC    = 8'hfc;
  localparam logic [7:0] LEAD_FE    = 8'hfe;
  localparam logic [7:0] LEAD_FF    = 8'hff;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_STRAY    = 3'd1,
    KIND_TRUNC    = 3'd2,
    KIND_BADCONT  = 3'd3,
    KIND_OVERLONG = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0]             data;
    logic                   last;
    logic [OFFSET_BITS-1:0] offset;
    logic                   sat;
    logic                   is_cont;
    logic [2:0]             extra;
    logic                   ovl_always;
    logic [7:0]             ovl_mask;
  } item_t;

  function automatic logic [2:0] extra_count(input logic [7:0] lead);
    logic [2:0] n;
    if (!lead[5])      n = 3'd1;
    else if (!lead[4]) n = 3'd2;
    else if (!lead[3]) n = 3'd3;
    else if (!lead[2]) n = 3'd4;
    else               n = 3'd5;
    return n;
  endfunction

endpackage

// File: rtl/u8sv_front.sv
// Front end: byte acceptance, offset counter and lead/continuation classification.
module u8sv_front import u8sv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output item_t      item_o
);

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   sat;
  logic [2:0]             extra;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign sat        = (pos_q == {OFFSET_BITS{1'b1}});
  assign extra      = extra_count(data_byte_i);

  always_comb begin
    item_o            = '0;
    item_o.data       = data_byte_i;
    item_o.last       = last_byte_i;
    item_o.offset     = pos_q;
    item_o.sat        = sat;
    item_o.is_cont    = (data_byte_i & MASK_TOP2) == CONT_CODE;
    item_o.extra      = extra;
    item_o.ovl_always = ((extra == 3'd1) && ((data_byte_i & TWO_OVL) == 8'h00))
                        || (data_byte_i == LEAD_FE) || (data_byte_i == LEAD_FF);
    case (data_byte_i)
      LEAD_E0: item_o.ovl_mask = E0_MASK;
      LEAD_F0: item_o.ovl_mask = F0_MASK;
      LEAD_F8: item_o.ovl_mask = F8_MASK;
      LEAD_FC: item_o.ovl_mask = FC_MASK;
      default: item_o.ovl_mask = 8'h00;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (last_byte_i) pos_d = '0;
      else if (!sat)   pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: rtl/u8sv_queue.sv
// Short queue of classified bytes between front and back end.
module u8sv_queue import u8sv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> (!full_o || pop_i))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count mismatch");

endmodule

// File: rtl/u8sv_back.sv
// Back end: sequence tracking, error priority and the registered result.
module u8sv_back import u8sv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_valid_o,
  output logic [OUT_OFF_W-1:0] bad_offset_o,
  output logic [2:0]           error_kind_o,
  output logic                 offset_saturated_o
);

  logic [2:0]             exp_q, exp_d;
  logic                   second_q, second_d;
  logic [OFFSET_BITS-1:0] lead_off_q, lead_off_d;
  logic                   ovl_always_q, ovl_always_d;
  logic [7:0]             ovl_mask_q, ovl_mask_d;
  logic                   pend_q, pend_d;
  logic [OFFSET_BITS-1:0] pend_off_q, pend_off_d;
  kind_e                  pend_kind_q, pend_kind_d;
  logic                   lat_q, lat_d;
  logic [OFFSET_BITS-1:0] lat_off_q, lat_off_d;
  kind_e                  lat_kind_q, lat_kind_d;

  logic                   out_valid_q;
  logic                   res_valid_q, res_valid_d;
  logic [OUT_OFF_W-1:0]   res_off_q, res_off_d;
  kind_e                  res_kind_q, res_kind_d;
  logic                   res_sat_q;

  logic                   slot_free;
  logic                   overlong;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = !empty_i && (!item_i.last || slot_free);
  assign overlong  = ovl_always_q ||
                     ((ovl_mask_q != 8'h00) && ((item_i.data & ovl_mask_q) == 8'h00));

  always_comb begin
    exp_d        = exp_q;
    second_d     = second_q;
    lead_off_d   = lead_off_q;
    ovl_always_d = ovl_always_q;
    ovl_mask_d   = ovl_mask_q;
    pend_d       = pend_q;
    pend_off_d   = pend_off_q;
    pend_kind_d  = pend_kind_q;
    lat_d        = lat_q;
    lat_off_d    = lat_off_q;
    lat_kind_d   = lat_kind_q;
    if (exp_q == 3'd0) begin
      if (!lat_q && item_i.data[7]) begin
        if (item_i.is_cont) begin
          lat_d      = 1'b1;
          lat_off_d  = item_i.offset;
          lat_kind_d = KIND_STRAY;
        end else begin
          exp_d        = item_i.extra;
          second_d     = 1'b1;
          lead_off_d   = item_i.offset;
          ovl_always_d = item_i.ovl_always;
          ovl_mask_d   = item_i.ovl_mask;
          pend_d       = 1'b0;
        end
      end
    end else begin
      if (!pend_q) begin
        if (!item_i.is_cont) begin
          pend_d      = 1'b1;
          pend_off_d  = item_i.offset;
          pend_kind_d = KIND_BADCONT;
        end else if (second_q && overlong) begin
          pend_d      = 1'b1;
          pend_off_d  = item_i.offset;
          pend_kind_d = KIND_OVERLONG;
        end
      end
      second_d = 1'b0;
      exp_d    = exp_q - 1'b1;
      if (exp_d == 3'd0) begin
        if (pend_d && !lat_q) begin
          lat_d      = 1'b1;
          lat_off_d  = pend_off_d;
          lat_kind_d = pend_kind_d;
        end
        pend_d = 1'b0;
      end
    end
  end

  always_comb begin
    res_valid_d = 1'b0;
    res_off_d   = '0;
    res_kind_d  = KIND_NONE;
    if ((exp_d != 3'd0) && !lat_d) begin
      res_off_d  = OUT_OFF_W'(lead_off_d);
      res_kind_d = KIND_TRUNC;
    end else if (lat_d) begin
      res_off_d  = OUT_OFF_W'(lat_off_d);
      res_kind_d = lat_kind_d;
    end else begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q        <= '0;
      second_q     <= 1'b0;
      lead_off_q   <= '0;
      ovl_always_q <= 1'b0;
      ovl_mask_q   <= '0;
      pend_q       <= 1'b0;
      pend_off_q   <= '0;
      pend_kind_q  <= KIND_NONE;
      lat_q        <= 1'b0;
      lat_off_q    <= '0;
      lat_kind_q   <= KIND_NONE;
    end else if (pop_o) begin
      if (item_i.last) begin
        exp_q        <= '0;
        second_q     <= 1'b0;
        lead_off_q   <= '0;
        ovl_always_q <= 1'b0;
        ovl_mask_q   <= '0;
        pend_q       <= 1'b0;
        pend_off_q   <= '0;
        pend_kind_q  <= KIND_NONE;
        lat_q        <= 1'b0;
        lat_off_q    <= '0;
        lat_kind_q   <= KIND_NONE;
      end else begin
        exp_q        <= exp_d;
        second_q     <= second_d;
        lead_off_q   <= lead_off_d;
        ovl_always_q <= ovl_always_d;
        ovl_mask_q   <= ovl_mask_d;
        pend_q       <= pend_d;
        pend_off_q   <= pend_off_d;
        pend_kind_q  <= pend_kind_d;
        lat_q        <= lat_d;
        lat_off_q    <= lat_off_d;
        lat_kind_q   <= lat_kind_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      res_valid_q <= res_valid_d;
      res_off_q   <= res_off_d;
      res_kind_q  <= res_kind_d;
      res_sat_q   <= item_i.sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign is_valid_o         = res_valid_q;
  assign bad_offset_o       = res_off_q;
  assign error_kind_o       = res_kind_q;
  assign offset_saturated_o = res_sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_valid_o) |-> (error_kind_o == KIND_NONE && bad_offset_o == '0))
    else $error("valid result carries error fields");
  assert property (@(posedge clk_i) disable iff (!rst_ni) exp_q <= 3'd5)
    else $error("pending continuation count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.last) |=> (out_valid_q && exp_q == 3'd0 && !lat_q))
    else $error("end of string did not produce result or clear state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(pop_o && item_i.last))
    else $error("result overwritten while held");

endmodule

// File: rtl/utf8_stream_validator.sv
// Result: registered when the back end pops the final byte of a string.
// Throughput: one byte per cycle unless a final byte waits on a held result.
// Input stalls only when the four-entry queue fills behind a held result.
// Reset: asynchronous active low; clears offset counter, queue and sequence state.
// Top level of the legacy six-byte UTF-8 stream validator.
module utf8_stream_validator import u8sv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_valid_o,
  output logic [OUT_OFF_W-1:0] bad_offset_o,
  output logic [2:0]           error_kind_o,
  output logic                 offset_saturated_o
);

  logic  q_full, q_empty, push, pop;
  item_t front_item, back_item;

  u8sv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  u8sv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (back_item)
  );

  u8sv_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (q_empty),
    .item_i             (back_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_valid_o         (is_valid_o),
    .bad_offset_o       (bad_offset_o),
    .error_kind_o       (error_kind_o),
    .offset_saturated_o (offset_saturated_o)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the legacy six-byte UTF-8 stream validator.
module testbench;
  import u8sv_pkg::*;

  typedef struct packed {
    logic                 is_valid;
    logic [OUT_OFF_W-1:0] bad_offset;
    kind_e                kind;
    logic                 saturated;
  } verdict_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    logic       drain;
  } transfer_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_STRAY,
    FLAW_BADCONT,
    FLAW_OVERLONG,
    FLAW_BADLEAD,
    FLAW_CUT
  } flaw_e;

  typedef enum int {
    GAPS_NONE,
    GAPS_FULL,
    GAPS_LIGHT
  } gap_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [7:0]           data_byte_i = '0;
  logic                 last_byte_i = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 is_valid_o;
  logic [OUT_OFF_W-1:0] bad_offset_o;
  logic [2:0]           error_kind_o;
  logic                 offset_saturated_o;

  utf8_stream_validator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_valid_o         (is_valid_o),
    .bad_offset_o       (bad_offset_o),
    .error_kind_o       (error_kind_o),
    .offset_saturated_o (offset_saturated_o)
  );

  always #6 clk_i = ~clk_i;

  // validator state for the string in progress
  logic [OFFSET_BITS-1:0] pos;
  logic [2:0]             cont_due;
  logic [2:0]             cont_seen;
  logic [7:0]             lead_byte;
  logic [OFFSET_BITS-1:0] lead_pos;
  logic                   seq_err;
  logic [OFFSET_BITS-1:0] seq_err_pos;
  kind_e                  seq_err_kind;
  logic                   str_err;
  logic [OFFSET_BITS-1:0] str_err_pos;
  kind_e                  str_err_kind;

  transfer_t  transfer_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] str_buf[$];
  int         verdicts_owed = 0;
  int         gap_count = 0;
  int         rx_wait = 0;
  logic       quiet_rx = 1'b0;
  gap_mode_e  gap_mode = GAPS_NONE;
  int         fail_count = 0;
  int         bytes_seen = 0;
  int         strings_checked = 0;
  int         kind_tally[8];

  function automatic logic [2:0] cont_bytes(input logic [7:0] lead);
    if (lead < 8'he0) return 3'd1;
    if (lead < 8'hf0) return 3'd2;
    if (lead < 8'hf8) return 3'd3;
    if (lead < 8'hfc) return 3'd4;
    return 3'd5;
  endfunction

  // overlong encodings and the forbidden leads FE/FF
  function automatic logic overlong_form(input logic [7:0] lead, input logic [7:0] second);
    case (cont_bytes(lead))
      3'd1:    return lead[5:1] == 5'd0;
      3'd2:    return lead == 8'he0 && !second[5];
      3'd3:    return lead == 8'hf0 && second[5:4] == 2'd0;
      3'd4:    return lead == 8'hf8 && second[5:3] == 3'd0;
      default: return lead >= 8'hfe || (lead == 8'hfc && second[5:2] == 4'd0);
    endcase
  endfunction

  task automatic clear_string_state();
    pos          = '0;
    cont_due     = '0;
    cont_seen    = '0;
    lead_byte    = '0;
    lead_pos     = '0;
    seq_err      = 1'b0;
    seq_err_pos  = '0;
    seq_err_kind = KIND_NONE;
    str_err      = 1'b0;
    str_err_pos  = '0;
    str_err_kind = KIND_NONE;
  endtask

  task automatic validate_byte(input logic [7:0] b, input logic fin,
                               output logic produced, output verdict_t v);
    logic [OFFSET_BITS-1:0] here;
    logic                   at_max;
    here     = pos;
    at_max   = &pos;
    produced = 1'b0;
    v        = '{1'b0, '0, KIND_NONE, 1'b0};
    if (cont_due == 3'd0) begin
      if (!str_err && b[7]) begin
        if (b[7:6] == 2'b10) begin
          str_err      = 1'b1;
          str_err_pos  = here;
          str_err_kind = KIND_STRAY;
        end else begin
          cont_due  = cont_bytes(b);
          cont_seen = 3'd0;
          lead_byte = b;
          lead_pos  = here;
          seq_err   = 1'b0;
        end
      end
    end else begin
      if (!seq_err) begin
        if (b[7:6] != 2'b10) begin
          seq_err      = 1'b1;
          seq_err_pos  = here;
          seq_err_kind = KIND_BADCONT;
        end else if (cont_seen == 3'd0 && overlong_form(lead_byte, b)) begin
          seq_err      = 1'b1;
          seq_err_pos  = here;
          seq_err_kind = KIND_OVERLONG;
        end
      end
      cont_seen = cont_seen + 3'd1;
      cont_due  = cont_due - 3'd1;
      if (cont_due == 3'd0 && seq_err && !str_err) begin
        str_err      = 1'b1;
        str_err_pos  = seq_err_pos;
        str_err_kind = seq_err_kind;
      end
      if (cont_due == 3'd0) seq_err = 1'b0;
    end
    if (!fin) begin
      if (!at_max) pos = pos + 1'b1;
    end else begin
      produced = 1'b1;
      // truncation outranks any error inside the open sequence
      if (cont_due != 3'd0 && !str_err) begin
        v.bad_offset = OUT_OFF_W'(lead_pos);
        v.kind       = KIND_TRUNC;
      end else if (str_err) begin
        v.bad_offset = OUT_OFF_W'(str_err_pos);
        v.kind       = str_err_kind;
      end else begin
        v.is_valid = 1'b1;
      end
      v.saturated = at_max;
      clear_string_state();
    end
  endtask

  // stimulus construction
  function automatic int draw_gap();
    case (gap_mode)
      GAPS_FULL:  return $urandom_range(0, 14);
      GAPS_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      default:    return 0;
    endcase
  endfunction

  task automatic send_string(input logic hold);
    transfer_t t;
    for (int i = 0; i < str_buf.size(); i++) begin
      t.data  = str_buf[i];
      t.last  = (i == str_buf.size() - 1);
      t.gap   = draw_gap();
      t.drain = hold && (i == 0);
      transfer_q.push_back(t);
    end
    str_buf.delete();
  endtask

  task automatic add_sequence(input flaw_e flaw);
    logic [7:0] seq[$];
    int         n;
    int         k;
    n = $urandom_range(1, 5);
    case (n)
      1:       seq.push_back(8'($urandom_range(8'hc2, 8'hdf)));
      2:       seq.push_back(8'($urandom_range(8'he0, 8'hef)));
      3:       seq.push_back(8'($urandom_range(8'hf0, 8'hf7)));
      4:       seq.push_back(8'($urandom_range(8'hf8, 8'hfb)));
      default: seq.push_back(8'($urandom_range(8'hfc, 8'hfd)));
    endcase
    for (k = 0; k < n; k++) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
    if (overlong_form(seq[0], seq[1])) seq[1] = seq[1] | 8'h20;
    case (flaw)
      FLAW_STRAY: str_buf.push_back(8'h80 | 8'($urandom_range(0, 63)));
      FLAW_BADCONT: begin
        k = $urandom_range(1, n);
        seq[k] = 8'($urandom);
        if (seq[k][7:6] == 2'b10) seq[k] = seq[k] | 8'h40;
      end
      FLAW_OVERLONG: begin
        case (n)
          1:       seq[0] = 8'($urandom_range(8'hc0, 8'hc1));
          2:       seq[0] = 8'he0;
          3:       seq[0] = 8'hf0;
          4:       seq[0] = 8'hf8;
          default: seq[0] = 8'hfc;
        endcase
        seq[1] = 8'h80 | (seq[1] & 8'h03);
      end
      FLAW_BADLEAD: begin
        seq[0] = 8'($urandom_range(8'hfe, 8'hff));
        while (seq.size() < 6) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
      FLAW_CUT: begin
        k = $urandom_range(1, n);
        repeat (k) void'(seq.pop_back());
      end
      default: ;
    endcase
    foreach (seq[i]) str_buf.push_back(seq[i]);
  endtask

  task automatic random_strings(input int count);
    int    pushed;
    int    units;
    flaw_e flaw;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 5) == 0) gap_mode = gap_mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 12)) str_buf.push_back(8'($urandom));
      end else begin
        units = $urandom_range(1, 5);
        repeat (units) begin
          if ($urandom_range(0, 1) == 0) begin
            str_buf.push_back(8'($urandom_range(0, 127)));
          end else begin
            flaw = ($urandom_range(0, 3) == 0) ? flaw_e'($urandom_range(1, 5)) : FLAW_NONE;
            add_sequence(flaw);
          end
        end
      end
      pushed += str_buf.size();
      send_string($urandom_range(0, 9) == 0);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    transfer_t nxt;
    logic      slot_free;
    logic      closing;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
      last_byte_i <= 1'b0;
      gap_count   <= 0;
    end else begin
      slot_free = !in_valid_i || in_ready_o;
      closing   = in_valid_i && in_ready_o && last_byte_i;
      if (slot_free) begin
        if (transfer_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_count < transfer_q[0].gap) begin
          gap_count  <= gap_count + 1;
          in_valid_i <= 1'b0;
        end else if (transfer_q[0].drain && (closing || verdicts_owed != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          nxt = transfer_q.pop_front();
          data_byte_i <= nxt.data;
          last_byte_i <= nxt.last;
          in_valid_i  <= 1'b1;
          gap_count   <= 0;
        end
      end
    end
  end

  // monitor: predicts on input transfers, checks output transfers
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    verdict_t pred;
    verdict_t want;
    logic     produced;
    int       w;
    if (!rst_ni) begin
      clear_string_state();
      out_ready_i   <= 1'b0;
      rx_wait       <= 0;
      verdicts_owed <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        validate_byte(data_byte_i, last_byte_i, produced, pred);
        bytes_seen++;
        if (produced) begin
          verdict_q.push_back(pred);
          kind_tally[pred.kind]++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: is_valid %0d, bad_offset %0d, error_kind %0d",
                 is_valid_o, bad_offset_o, error_kind_o);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          strings_checked++;
          if (is_valid_o !== want.is_valid) begin
            $error("is_valid: expected %0d, got %0d", want.is_valid, is_valid_o);
            fail_count++;
          end
          if (bad_offset_o !== want.bad_offset) begin
            $error("bad_offset: expected %0d, got %0d", want.bad_offset, bad_offset_o);
            fail_count++;
          end
          if (error_kind_o !== want.kind) begin
            $error("error_kind: expected %0d, got %0d", want.kind, error_kind_o);
            fail_count++;
          end
          if (offset_saturated_o !== want.saturated) begin
            $error("offset_saturated: expected %0d, got %0d",
                   want.saturated, offset_saturated_o);
            fail_count++;
          end
        end
        if ($urandom_range(0, 7) == 0) quiet_rx = !quiet_rx;
        w = quiet_rx ? 0 : $urandom_range(0, 14);
        out_ready_i <= (w == 0);
        rx_wait     <= (w > 0) ? w - 1 : 0;
      end else if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait     <= rx_wait - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
      verdicts_owed <= verdict_q.size();
    end
  end

  initial begin
    // directed strings
    str_buf = {8'h7f};                                     send_string(1'b0);
    str_buf = {8'h80};                                     send_string(1'b0);
    str_buf = {8'hc0, 8'h80};                              send_string(1'b0);
    str_buf = {8'he0, 8'h80, 8'h80};                       send_string(1'b0);
    str_buf = {8'he1, 8'h41};                              send_string(1'b0);
    str_buf = {8'h41, 8'hc3, 8'h28};                       send_string(1'b0);
    str_buf = {8'hfc, 8'h84, 8'h80, 8'h80, 8'h80, 8'hbf};  send_string(1'b0);
    str_buf = {8'hfe, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};  send_string(1'b0);
    str_buf = {8'h00};                                     send_string(1'b1);

    random_strings(250);
    random_strings(250);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (transfer_q.size() != 0 || in_valid_i || verdicts_owed != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      fail_count++;
    end

    $display("Checked %0d strings over %0d bytes with random stalls on both sides.",
             strings_checked, bytes_seen);
    $display("Verdicts: %0d valid, %0d stray, %0d truncated, %0d bad cont, %0d overlong/lead.",
             kind_tally[KIND_NONE], kind_tally[KIND_STRAY], kind_tally[KIND_TRUNC],
             kind_tally[KIND_BADCONT], kind_tally[KIND_OVERLONG]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
